// ===== rtl/btl_pkg.sv =====
// Shared types and constants of the BASIC token lexer.
// Depends on nothing; imported by every lexer module.
`default_nettype none

package btl_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_STRING = 3'd2,
        KIND_OPER   = 3'd3,
        KIND_END    = 3'd4
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NUMBER = 3'd1,
        MODE_IDENT  = 3'd2,
        MODE_STRING = 3'd3,
        MODE_LT     = 3'd4,
        MODE_GT     = 3'd5
    } lex_mode_t;

    // one reported character
    typedef struct packed {
        logic [7:0] ch;
        tok_kind_t  kind;
        logic       value;
        logic       first;
        logic       last;
    } beat_t;

    // everything one request causes: the held character and/or an end token
    typedef struct packed {
        logic  held_ok;
        logic  end_ok;
        beat_t held;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/btl_front.sv =====
// Front end: accepts source bytes, runs the one-character lookahead lexer
// and pushes the results of each request into the queue. Uses btl_pkg.
`default_nettype none

module btl_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [7:0]          text_byte,
    input  wire                 accept,
    output logic                push,
    output btl_pkg::entry_t     entry
);
    import btl_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic       held_valid_reg, held_valid_next;
    beat_t      held_reg, held_next;

    logic       is_digit, is_alpha, is_space, cont, val;
    lex_mode_t  cont_mode;

    always_comb
    begin
        is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                   ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
        is_space = text_byte inside {8'h20, [8'h09:8'h0D]};

        cont      = 1'b0;
        cont_mode = MODE_IDLE;
        val       = 1'b1;
        case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit || text_byte == CH_DOT)
                begin
                    cont      = 1'b1;
                    cont_mode = MODE_NUMBER;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    cont      = 1'b1;
                    cont_mode = MODE_IDENT;
                end
                else if (text_byte == CH_DOLLAR)
                begin
                    cont = 1'b1;
                end
            end
            MODE_STRING:
            begin
                cont = 1'b1;
                if (text_byte == CH_QUOTE)
                    val = 1'b0;
                else
                    cont_mode = MODE_STRING;
            end
            MODE_LT:
            begin
                cont = (text_byte == CH_GT) || (text_byte == CH_EQ);
            end
            MODE_GT:
            begin
                cont = (text_byte == CH_EQ);
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase

        entry.held_ok   = held_valid_reg;
        entry.end_ok    = (text_byte == CH_END);
        entry.held      = held_reg;
        entry.held.last = (text_byte == CH_END) || !cont;
        push = accept && (held_valid_reg || text_byte == CH_END);

        mode_next       = mode_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        if (accept)
        begin
            held_next.ch    = text_byte;
            held_next.last  = 1'b0;
            held_next.first = 1'b1;
            held_next.value = 1'b1;
            held_valid_next = 1'b1;
            if (text_byte == CH_END)
            begin
                mode_next       = MODE_IDLE;
                held_valid_next = 1'b0;
                held_next       = '0;
            end
            else if (cont && held_valid_reg)
            begin
                held_next.first = 1'b0;
                held_next.value = val;
                mode_next       = cont_mode;
            end
            else if (is_space)
            begin
                held_valid_next = 1'b0;
                held_next       = held_reg;
                mode_next       = MODE_IDLE;
            end
            else if (is_digit)
            begin
                held_next.kind = KIND_NUMBER;
                mode_next      = MODE_NUMBER;
            end
            else if (is_alpha)
            begin
                held_next.kind = KIND_IDENT;
                mode_next      = MODE_IDENT;
            end
            else if (text_byte == CH_QUOTE)
            begin
                held_next.kind  = KIND_STRING;
                held_next.value = 1'b0;
                mode_next       = MODE_STRING;
            end
            else
            begin
                held_next.kind = KIND_OPER;
                if (text_byte == CH_LT)
                    mode_next = MODE_LT;
                else if (text_byte == CH_GT)
                    mode_next = MODE_GT;
                else
                    mode_next = MODE_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btl_queue.sv =====
// Short queue of lexer results between front and back end.
// Uses btl_pkg for the entry and status types.
`default_nettype none

module btl_queue #(
    parameter int DEPTH = btl_pkg::QUEUE_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  btl_pkg::entry_t      push_entry,
    input  wire                  pop,
    output btl_pkg::entry_t      head,
    output btl_pkg::queue_stat_t stat
);
    import btl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    entry_t         mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    always_comb
    begin
        stat.empty = (count_reg == '0);
        stat.full  = (count_reg == CNT_FULL);
        head       = mem_reg[rd_ptr_reg];
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/btl_back.sv =====
// Back end: expands queue entries into one or two result beats and drives
// the registered output stream. Uses btl_pkg.
`default_nettype none

module btl_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  btl_pkg::entry_t      head,
    input  btl_pkg::queue_stat_t stat,
    output logic                 pop,
    input  wire                  out_ready,
    output logic                 out_valid,
    output btl_pkg::beat_t       out_beat,
    output logic                 out_last
);
    import btl_pkg::*;

    logic   valid_reg, valid_next;
    logic   phase_reg, phase_next;     // held character of head already sent
    beat_t  beat_reg, beat_next;
    logic   last_reg, last_next;
    logic   load;

    always_comb
    begin
        load       = !valid_reg || out_ready;
        valid_next = valid_reg;
        phase_next = phase_reg;
        beat_next  = beat_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = !stat.empty;
            if (!stat.empty)
            begin
                if (head.held_ok && !phase_reg)
                begin
                    beat_next = head.held;
                    last_next = !head.end_ok;
                    if (head.end_ok)
                        phase_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    beat_next.ch    = CH_END;
                    beat_next.kind  = KIND_END;
                    beat_next.value = 1'b0;
                    beat_next.first = 1'b1;
                    beat_next.last  = 1'b1;
                    last_next       = 1'b1;
                    phase_next      = 1'b0;
                    pop             = 1'b1;
                end
            end
        end

        out_valid = valid_reg;
        out_beat  = beat_reg;
        out_last  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/basic_token_lexer.sv =====
// Top level of the BASIC token lexer: front end, result queue, back end.
// Depends on btl_pkg, btl_front, btl_queue and btl_back.
//
// Usage:
//   s_axis carries one source byte per request; byte 0 ends the text.
//   m_axis carries one reported character per request, tagged with its
//   token kind and flags; tlast marks the final result caused by one byte.
//   Each byte but a blank outside a string is reported once the following
//   byte arrives; byte 0 flushes the held byte (if any) and then yields an end token.
//   A result is written into the queue when the byte that causes it is
//   taken and then moves through the output register to m_axis.
//   Throughput: one byte per cycle while the queue is not full; byte 0 with
//   a held byte yields two output beats, the queue absorbs the extra beat.
//   When m_axis stalls, the output register holds, the queue fills and
//   s_axis_tready drops once the queue is full.
//   Reset clears the lexer state, the queue and the output stage; the
//   block is idle with nothing held.
`default_nettype none

module basic_token_lexer #(
    parameter int QUEUE_DEPTH = btl_pkg::QUEUE_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [8] token_first, [9] token_last
    output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] is_value_char
    output logic        m_axis_tlast    // last_of_run
);
    import btl_pkg::*;

    logic         accept;
    logic         q_push, q_pop;
    entry_t       q_entry, q_head;
    queue_stat_t  q_stat;
    beat_t        m_beat;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    btl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (s_axis_tdata),
        .accept    (accept),
        .push      (q_push),
        .entry     (q_entry)
    );

    btl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    btl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .stat      (q_stat),
        .pop       (q_pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_beat  (m_beat),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, m_beat.last, m_beat.first, m_beat.ch};
    assign m_axis_tuser = {m_beat.value, m_beat.kind};

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_beat.kind == KIND_END) |->
            (m_axis_tlast && m_beat.first && m_beat.last && m_beat.ch == CH_END))
        else $error("end token beat malformed");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.end_ok && q_entry.held_ok) |-> q_entry.held.last)
        else $error("flushed character not closing its token");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for basic_token_lexer: directed rows, then random BASIC-like text.
// Predicts every reported character and compares it field by field on m_axis.
// Depends on btl_pkg and the basic_token_lexer RTL.
module tb_top;
    import btl_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 600;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // + - * / ( ) , ; : ^
    localparam logic [7:0] PUNCT [10] = '{8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28,
                                          8'h29, 8'h2C, 8'h3B, 8'h3A, 8'h5E};

    typedef struct packed {
        logic [7:0] ch;
        tok_kind_t  kind;
        logic       value;
        logic       opens;
        logic       closes;
        logic       run_end;
    } tok_report_t;

    typedef struct {
        logic [7:0]  b;
        bit          typed;
        int          n;
        tok_report_t r0;
        tok_report_t r1;
    } stim_row_t;

    localparam tok_report_t NIL = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // [7:0] char_out, [8] token_first, [9] token_last
    logic [3:0]  m_axis_tuser;   // [2:0] token_kind, [3] is_value_char
    logic        m_axis_tlast;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit sink_hold_req = 1'b0;
    int mismatches = 0;
    int quiet;

    tok_report_t due_reports [$];
    stim_row_t   dir_rows [$];
    logic [7:0]  text_q [$];
    tok_report_t want_rep;

    // predictor state
    lex_mode_t   lx_mode;
    logic        hold_ok;
    logic [7:0]  hold_ch;
    tok_kind_t   hold_kind;
    logic        hold_opens;
    logic        hold_val;
    tok_report_t step_rep [2];
    int          step_cnt;

    always #HALF_PERIOD clk = ~clk;

    basic_token_lexer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic tok_report_t rep(logic [7:0] ch, tok_kind_t k, logic v,
                                        logic o, logic c, logic r);
        tok_report_t t;
        t.ch = ch;
        t.kind = k;
        t.value = v;
        t.opens = o;
        t.closes = c;
        t.run_end = r;
        return t;
    endfunction

    function automatic bit is_numeral(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic lex_clear();
        lx_mode = MODE_IDLE;
        hold_ok = 1'b0;
        hold_ch = 8'h00;
        hold_kind = KIND_NUMBER;
        hold_opens = 1'b0;
        hold_val = 1'b0;
    endtask

    task automatic take(logic [7:0] c, tok_kind_t k, logic v);
        hold_ok = 1'b1;
        hold_ch = c;
        hold_kind = k;
        hold_opens = 1'b1;
        hold_val = v;
    endtask

    // one source byte: fills step_rep[0 .. step_cnt-1]
    task automatic lex_step(input logic [7:0] c);
        logic      cont;
        lex_mode_t nxt;
        logic      v;
        cont = 1'b0;
        nxt = MODE_IDLE;
        v = 1'b1;
        step_cnt = 0;
        if (c == CH_END)
        begin
            if (hold_ok)
            begin
                step_rep[step_cnt] = rep(hold_ch, hold_kind, hold_val, hold_opens, 1'b1, 1'b0);
                step_cnt++;
            end
            step_rep[step_cnt] = rep(CH_END, KIND_END, 1'b0, 1'b1, 1'b1, 1'b1);
            step_cnt++;
            lex_clear();
        end
        else
        begin
            case (lx_mode)
                MODE_NUMBER:
                    if (is_numeral(c) || c == CH_DOT)
                    begin
                        cont = 1'b1;
                        nxt = MODE_NUMBER;
                    end
                MODE_IDENT:
                    if (is_letter(c) || is_numeral(c))
                    begin
                        cont = 1'b1;
                        nxt = MODE_IDENT;
                    end
                    else if (c == CH_DOLLAR)
                        cont = 1'b1;
                MODE_STRING:
                begin
                    cont = 1'b1;
                    if (c == CH_QUOTE)
                        v = 1'b0;
                    else
                        nxt = MODE_STRING;
                end
                MODE_LT:
                    if (c == CH_GT || c == CH_EQ)
                        cont = 1'b1;
                MODE_GT:
                    if (c == CH_EQ)
                        cont = 1'b1;
                default:
                    ;
            endcase
            if (hold_ok)
            begin
                step_rep[step_cnt] = rep(hold_ch, hold_kind, hold_val, hold_opens, !cont, 1'b1);
                step_cnt++;
            end
            if (cont && hold_ok)
            begin
                hold_ch = c;
                hold_opens = 1'b0;
                hold_val = v;
                lx_mode = nxt;
            end
            else if (is_blank(c))
            begin
                hold_ok = 1'b0;
                lx_mode = MODE_IDLE;
            end
            else if (is_numeral(c))
            begin
                take(c, KIND_NUMBER, 1'b1);
                lx_mode = MODE_NUMBER;
            end
            else if (is_letter(c))
            begin
                take(c, KIND_IDENT, 1'b1);
                lx_mode = MODE_IDENT;
            end
            else if (c == CH_QUOTE)
            begin
                take(c, KIND_STRING, 1'b0);
                lx_mode = MODE_STRING;
            end
            else
            begin
                take(c, KIND_OPER, 1'b1);
                lx_mode = (c == CH_LT) ? MODE_LT : (c == CH_GT) ? MODE_GT : MODE_IDLE;
            end
        end
    endtask

    task automatic offer(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic feed(input logic [7:0] b);
        offer(b);
        lex_step(b);
        for (int i = 0; i < step_cnt; i++)
            due_reports.push_back(step_rep[i]);
    endtask

    task automatic add_row(logic [7:0] b, bit typed, int n, tok_report_t r0, tok_report_t r1);
        stim_row_t row;
        row.b = b;
        row.typed = typed;
        row.n = n;
        row.r0 = r0;
        row.r1 = r1;
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(CH_UP_A + $urandom_range(0, 25))
                                    : 8'(CH_LO_A + $urandom_range(0, 25));
    endfunction

    // mostly well-formed statements ending in byte 0, sometimes raw noise
    task automatic build_text();
        logic [7:0] b;
        text_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        text_q.push_back(rand_digit());
                        repeat ($urandom_range(0, 5))
                            text_q.push_back($urandom_range(0, 3) == 0 ? CH_DOT : rand_digit());
                    end
                    3, 4:
                    begin
                        text_q.push_back(rand_letter());
                        repeat ($urandom_range(0, 5))
                            text_q.push_back($urandom_range(0, 2) == 0 ? rand_digit()
                                                                       : rand_letter());
                        if ($urandom_range(0, 2) == 0)
                            text_q.push_back(CH_DOLLAR);
                    end
                    5, 6:
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                text_q.push_back(CH_LT);
                                case ($urandom_range(0, 2))
                                    0: text_q.push_back(CH_GT);
                                    1: text_q.push_back(CH_EQ);
                                    default: ;
                                endcase
                            end
                            1:
                            begin
                                text_q.push_back(CH_GT);
                                if ($urandom_range(0, 1))
                                    text_q.push_back(CH_EQ);
                            end
                            2: text_q.push_back(8'($urandom_range(128, 255)));
                            3: text_q.push_back($urandom_range(0, 1) ? CH_DOT : CH_EQ);
                            default: text_q.push_back(PUNCT[$urandom_range(0, 9)]);
                        endcase
                    end
                    7:
                    begin
                        text_q.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 6))
                        begin
                            do
                                b = 8'($urandom_range(1, 255));
                            while (b == CH_QUOTE);
                            text_q.push_back(b);
                        end
                        if ($urandom_range(0, 9) != 0)
                            text_q.push_back(CH_QUOTE);
                    end
                    8:
                        repeat ($urandom_range(1, 3))
                            text_q.push_back(rand_blank());
                    default:
                        text_q.push_back(8'($urandom_range(1, 255)));
                endcase
                if ($urandom_range(0, 1))
                    text_q.push_back(rand_blank());
            end
            text_q.push_back(CH_END);
        end
    endtask

    task automatic run_random(int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            build_text();
            foreach (text_q[i])
                feed(text_q[i]);
            sent += text_q.size();
        end
    endtask

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_reports.size() == 0)
            begin
                $error("char_out: expected nothing, got %0h", m_axis_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                want_rep = due_reports.pop_front();
                check_field("char_out", want_rep.ch, m_axis_tdata[7:0]);
                check_field("token_kind", 8'(want_rep.kind), 8'(m_axis_tuser[2:0]));
                check_field("is_value_char", 8'(want_rep.value), 8'(m_axis_tuser[3]));
                check_field("token_first", 8'(want_rep.opens), 8'(m_axis_tdata[8]));
                check_field("token_last", 8'(want_rep.closes), 8'(m_axis_tdata[9]));
                check_field("last_of_run", 8'(want_rep.run_end), 8'(m_axis_tlast));
            end
        end
    end

    // receiver; a hold request blocks it for a long stretch so the block backs up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        lex_clear();
        add_row(8'h41, 1'b1, 0, NIL, NIL);   // 'A', first byte of a text
        add_row(8'h00, 1'b1, 2, rep(8'h41, KIND_IDENT, 1'b1, 1'b1, 1'b1, 1'b0),
                                rep(8'h00, KIND_END, 1'b0, 1'b1, 1'b1, 1'b1));
        add_row(8'h00, 1'b1, 1, rep(8'h00, KIND_END, 1'b0, 1'b1, 1'b1, 1'b1), NIL);
        add_row(8'hFF, 1'b1, 0, NIL, NIL);
        add_row(8'h80, 1'b1, 1, rep(8'hFF, KIND_OPER, 1'b1, 1'b1, 1'b1, 1'b1), NIL);
        add_row(8'h20, 1'b0, 0, NIL, NIL);   // space
        add_row(8'h39, 1'b0, 0, NIL, NIL);   // 9.5
        add_row(8'h2E, 1'b0, 0, NIL, NIL);
        add_row(8'h35, 1'b0, 0, NIL, NIL);
        add_row(8'h78, 1'b0, 0, NIL, NIL);   // x$ then a lone $
        add_row(8'h24, 1'b0, 0, NIL, NIL);
        add_row(8'h24, 1'b0, 0, NIL, NIL);
        add_row(8'h3C, 1'b0, 0, NIL, NIL);   // <>
        add_row(8'h3E, 1'b0, 0, NIL, NIL);
        add_row(8'h3E, 1'b0, 0, NIL, NIL);   // >=
        add_row(8'h3D, 1'b0, 0, NIL, NIL);
        add_row(8'h3C, 1'b0, 0, NIL, NIL);   // <=
        add_row(8'h3D, 1'b0, 0, NIL, NIL);
        add_row(8'h2E, 1'b0, 0, NIL, NIL);   // leading dot
        add_row(8'h22, 1'b0, 0, NIL, NIL);   // "<tab>"
        add_row(8'h09, 1'b0, 0, NIL, NIL);
        add_row(8'h22, 1'b0, 0, NIL, NIL);
        add_row(8'h22, 1'b0, 0, NIL, NIL);   // "z left open
        add_row(8'h7A, 1'b0, 0, NIL, NIL);
        add_row(8'h00, 1'b0, 0, NIL, NIL);

        src_idle_pct = 32;
        sink_idle_pct = 66;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            offer(dir_rows[i].b);
            lex_step(dir_rows[i].b);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].n > 0)
                    due_reports.push_back(dir_rows[i].r0);
                if (dir_rows[i].n > 1)
                    due_reports.push_back(dir_rows[i].r1);
            end
            else
            begin
                for (int k = 0; k < step_cnt; k++)
                    due_reports.push_back(step_rep[k]);
            end
        end

        sink_hold_req = 1'b1;
        run_random(PHASE_ITEMS);
        src_idle_pct = 66;
        sink_idle_pct = 32;
        run_random(PHASE_ITEMS);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random(PHASE_ITEMS);
        s_axis_tvalid <= 1'b0;

        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
